>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on i_clk, quiet while i_rst_n is low.
`define AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication on i_clk, quiet while i_rst_n is low.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/dwpr_pkg.sv
// Shared codes, widths and types of the deque block.
package dwpr_pkg;

    localparam int DEF_LINE_DEPTH = 32;
    localparam int DEF_TAG_WIDTH  = 16;

    localparam int MODE_W   = 3;
    localparam int ENTRY_W  = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // wide enough for a cell index at the deepest allowed line
    localparam int CMD_IDX_W = 10;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [1:0] ACT_HOLD    = 2'd0;
    localparam logic [1:0] ACT_LOAD_AT = 2'd1;
    localparam logic [1:0] ACT_INSERT  = 2'd2;
    localparam logic [1:0] ACT_CLOSE   = 2'd3;

    typedef struct packed {
        logic [1:0]           act;
        logic                 sel_en;
        logic [CMD_IDX_W-1:0] idx;
    } t_cell_cmd;

endpackage

>>> rtl/core/dwpr_cell.sv
// One slot of the entry chain: hold, load, or take a neighbor's word.
module dwpr_cell #(
    parameter int TAG_WIDTH = 16,
    parameter int INDEX     = 0
) (
    input  logic                  i_clk,
    input  dwpr_pkg::t_cell_cmd   i_cmd,
    input  logic [TAG_WIDTH-1:0]  i_tag,
    input  logic [TAG_WIDTH-1:0]  i_prev,
    input  logic [TAG_WIDTH-1:0]  i_next,
    output logic [TAG_WIDTH-1:0]  o_value,
    output logic [TAG_WIDTH-1:0]  o_tap
);
    import dwpr_pkg::*;

    localparam logic [CMD_IDX_W-1:0] MY_IDX = CMD_IDX_W'(INDEX);

    logic [TAG_WIDTH-1:0] r_value;
    logic [TAG_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.act)
            ACT_LOAD_AT: begin
                if (i_cmd.idx == MY_IDX) n_value = i_tag;
            end
            ACT_INSERT: begin
                n_value = (INDEX == 0) ? i_tag : i_prev;
            end
            ACT_CLOSE: begin
                // close the gap: everything at or behind the hole moves up
                if (MY_IDX >= i_cmd.idx) n_value = i_next;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (i_cmd.sel_en && (i_cmd.idx == MY_IDX)) ? r_value : '0;

endmodule

>>> rtl/core/dwpr_reducer.sv
// Registered OR reduction of the cell taps, halving once per cycle.
module dwpr_reducer #(
    parameter int N = 32,
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_result
);
    logic [W-1:0] r_node [N];

    // after k steps node i covers leaves [i*2^k, (i+1)*2^k)
    for (genvar i = 0; i < N; i++) begin : g_node
        localparam int LI = 2 * i;
        localparam int RI = 2 * i + 1;
        logic [W-1:0] n_node;

        if (RI < N) begin : g_two
            assign n_node = r_node[LI] | r_node[RI];
        end else if (LI < N) begin : g_one
            assign n_node = r_node[LI];
        end else begin : g_none
            assign n_node = '0;
        end

        always_ff @(posedge i_clk) begin
            r_node[i] <= i_load ? i_leaf[i] : n_node;
        end
    end

    assign o_result = r_node[0];

endmodule

>>> rtl/core/deque_with_positional_removal.sv
// Top level of the bounded deque with removal and read at a position.
// One operation is taken at a time and gives one result word. The entry
// read or removed comes out of the shared registered OR-reduction over
// the cells, which halves its span once per cycle; the entry chain then
// applies the operation, and the new back entry comes out of a second
// pass of the same reduction. The result sits in an output register, so
// the next item is taken while a result still waits. Pushes onto a full
// line are dropped with status full; pops, removes and reads that find
// nothing give status none and a zero entry; modes 6 and 7 change nothing.
module deque_with_positional_removal #(
    parameter int LINE_DEPTH = dwpr_pkg::DEF_LINE_DEPTH,
    parameter int TAG_WIDTH  = dwpr_pkg::DEF_TAG_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dwpr_pkg::MODE_W-1:0]    i_mode,
    input  logic [dwpr_pkg::ENTRY_W-1:0]   i_entry_value,
    input  logic [dwpr_pkg::POS_W-1:0]     i_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dwpr_pkg::ENTRY_W-1:0]   o_entry_out,
    output logic [dwpr_pkg::STATUS_W-1:0]  o_status,
    output logic [dwpr_pkg::COUNT_W-1:0]   o_count,
    output logic [dwpr_pkg::ENTRY_W-1:0]   o_front_value,
    output logic [dwpr_pkg::ENTRY_W-1:0]   o_back_value
);
    import dwpr_pkg::*;

    localparam int CW   = $clog2(LINE_DEPTH + 1);
    localparam int LOG  = $clog2(LINE_DEPTH);
    localparam int SW   = $clog2(LOG + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADG = 3'd1;
    localparam logic [2:0] S_REDG  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_LOADB = 3'd4;
    localparam logic [2:0] S_REDB  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           r_state;
    logic [MODE_W-1:0]    r_mode;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [POS_W-1:0]     r_pos;
    logic [CW-1:0]        r_count;
    logic [SW-1:0]        r_step;
    logic [TAG_WIDTH-1:0] r_got;
    logic [STATUS_W-1:0]  r_status;

    logic                 r_out_valid;
    logic [ENTRY_W-1:0]   r_entry_out;
    logic [STATUS_W-1:0]  r_status_out;
    logic [COUNT_W-1:0]   r_count_out;
    logic [ENTRY_W-1:0]   r_front;
    logic [ENTRY_W-1:0]   r_back;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_pos_out;
    logic [STATUS_W-1:0]  w_status;
    logic                 w_takes;
    logic [1:0]           w_act;
    logic [CMD_IDX_W-1:0] w_idx;
    logic [CW-1:0]        w_count_next;
    t_cell_cmd            w_cmd;

    logic [TAG_WIDTH-1:0] w_value [LINE_DEPTH];
    logic [TAG_WIDTH-1:0] w_tap   [LINE_DEPTH];
    logic [TAG_WIDTH-1:0] w_red;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_full    = (r_count == CW'(LINE_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_pos_out = (CMPW'(r_pos) >= CMPW'(r_count));

    // decode the held operation against the count before it is applied
    always_comb begin
        w_status     = ST_OK;
        w_takes      = 1'b0;
        w_act        = ACT_HOLD;
        w_idx        = '0;
        w_count_next = r_count;
        unique case (r_mode) inside
            MODE_PUSH_BACK: begin
                w_status = w_full ? ST_FULL : ST_OK;
                w_act    = ACT_LOAD_AT;
                w_idx    = CMD_IDX_W'(r_count);
                if (!w_full) w_count_next = r_count + 1'b1;
            end
            MODE_PUSH_FRONT: begin
                w_status = w_full ? ST_FULL : ST_OK;
                w_act    = ACT_INSERT;
                if (!w_full) w_count_next = r_count + 1'b1;
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                w_status = w_empty ? ST_NONE : ST_OK;
                w_takes  = !w_empty;
                w_act    = (r_mode == MODE_POP_FRONT) ? ACT_CLOSE : ACT_HOLD;
                w_idx    = (r_mode == MODE_POP_FRONT) ? '0
                                                      : CMD_IDX_W'(r_count - 1'b1);
                if (!w_empty) w_count_next = r_count - 1'b1;
            end
            MODE_REMOVE, MODE_READ: begin
                w_status = w_pos_out ? ST_NONE : ST_OK;
                w_takes  = !w_pos_out;
                w_act    = (r_mode == MODE_REMOVE) ? ACT_CLOSE : ACT_HOLD;
                w_idx    = CMD_IDX_W'(r_pos);
                if (!w_pos_out && (r_mode == MODE_REMOVE)) w_count_next = r_count - 1'b1;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        w_cmd.act    = ACT_HOLD;
        w_cmd.sel_en = 1'b0;
        w_cmd.idx    = '0;
        unique case (r_state)
            S_LOADG: begin
                w_cmd.sel_en = 1'b1;
                w_cmd.idx    = w_idx;
            end
            S_APPLY: begin
                if (w_status == ST_OK) w_cmd.act = w_act;
                w_cmd.idx = w_idx;
            end
            S_LOADB: begin
                w_cmd.sel_en = 1'b1;
                w_cmd.idx    = CMD_IDX_W'(r_count - 1'b1);
            end
            default: begin
                w_cmd.act = ACT_HOLD;
            end
        endcase
    end

    for (genvar j = 0; j < LINE_DEPTH; j++) begin : g_cell
        logic [TAG_WIDTH-1:0] w_prev;
        logic [TAG_WIDTH-1:0] w_next;

        if (j == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_value[j-1];
        end
        if (j == LINE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_value[j+1];
        end

        dwpr_cell #(
            .TAG_WIDTH (TAG_WIDTH),
            .INDEX     (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_tag   (r_tag),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_value[j]),
            .o_tap   (w_tap[j])
        );
    end

    dwpr_reducer #(
        .N (LINE_DEPTH),
        .W (TAG_WIDTH)
    ) u_reducer (
        .i_clk    (i_clk),
        .i_load   ((r_state == S_LOADG) || (r_state == S_LOADB)),
        .i_leaf   (w_tap),
        .o_result (w_red)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_LOADG;
                end
                S_LOADG: begin
                    r_state <= S_REDG;
                end
                S_REDG: begin
                    if (r_step == SW'(LOG - 1)) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_count <= w_count_next;
                    r_state <= S_LOADB;
                end
                S_LOADB: begin
                    r_state <= S_REDB;
                end
                S_REDB: begin
                    if (r_step == SW'(LOG - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register frees up
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_tag  <= TAG_WIDTH'(i_entry_value);
            r_pos  <= i_position;
        end
        if ((r_state == S_LOADG) || (r_state == S_LOADB)) begin
            r_step <= '0;
        end else begin
            r_step <= r_step + 1'b1;
        end
        if (r_state == S_APPLY) begin
            r_status <= w_status;
            r_got    <= w_takes ? w_red : '0;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_entry_out  <= ENTRY_W'(r_got);
            r_status_out <= r_status;
            r_count_out  <= COUNT_W'(r_count);
            r_front      <= w_empty ? '0 : ENTRY_W'(w_value[0]);
            r_back       <= w_empty ? '0 : ENTRY_W'(w_red);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_out   = r_entry_out;
    assign o_status      = r_status_out;
    assign o_count       = r_count_out;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;

endmodule

>>> rtl/core/dwpr_checker.sv
// Port-level checks of the deque block, bound to its top level.
`include "assert_macros.svh"

module dwpr_checker #(
    parameter int LINE_DEPTH = dwpr_pkg::DEF_LINE_DEPTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [dwpr_pkg::ENTRY_W-1:0]   o_entry_out,
    input logic [dwpr_pkg::STATUS_W-1:0]  o_status,
    input logic [dwpr_pkg::COUNT_W-1:0]   o_count,
    input logic [dwpr_pkg::ENTRY_W-1:0]   o_front_value,
    input logic [dwpr_pkg::ENTRY_W-1:0]   o_back_value
);
    import dwpr_pkg::*;

    // a stalled result word holds
    `AST_NEXT(a_out_hold, o_out_valid && i_out_stall,
              o_out_valid && $stable(o_entry_out) && $stable(o_status) && $stable(o_count))

    // one operation at a time: busy right after a word is taken
    `AST_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    `AST_NOW(a_full_count, o_out_valid && (o_status == ST_FULL),
             o_count == COUNT_W'(LINE_DEPTH))

    `AST_NOW(a_empty_ends, o_out_valid && (o_count == '0),
             (o_front_value == '0) && (o_back_value == '0))

    `AST_NOW(a_none_zero, o_out_valid && (o_status == ST_NONE), o_entry_out == '0)

endmodule

bind deque_with_positional_removal dwpr_checker #(
    .LINE_DEPTH (LINE_DEPTH)
) u_dwpr_checker (.*);
